// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the sorting line controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that must be followed by a consequence in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cscc_pkg.sv =====
// Types and constants of the color sorting conveyor controller.
package cscc_pkg;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_SENSE = 2'd1,
    PH_MOVE  = 2'd2,
    PH_EJECT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_WHITE = 2'd1,
    CLS_RED   = 2'd2,
    CLS_BLUE  = 2'd3
  } class_t;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 14;
  localparam int LIMIT_BITS     = 14;
  localparam int STEP_BITS      = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_START   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WHITE_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_WHITE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_RED   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEPS_BLUE  = 3'd5;

  localparam int MIN_START_RESET   = 10000;
  localparam int WHITE_LIMIT_RESET = 2500;
  localparam int RED_LIMIT_RESET   = 5000;

  localparam logic [STEP_BITS-1:0] STEPS_WHITE_RESET = 5'd4;
  localparam logic [STEP_BITS-1:0] STEPS_RED_RESET   = 5'd9;
  localparam logic [STEP_BITS-1:0] STEPS_BLUE_RESET  = 5'd13;

  typedef struct packed {
    logic       conveyor_on;
    logic       compressor_on;
    logic       eject_white;
    logic       eject_red;
    logic       eject_blue;
    logic       lamp_white;
    logic       lamp_red;
    logic       lamp_blue;
    logic [1:0] phase_now;
  } result_t;

endpackage

// ===== hdl/cscc_if.sv =====
// Handshake channels of the color sorting conveyor controller.
interface cscc_item_if #(
  parameter int SAMPLE_BITS = 14
) ();
  logic                   valid;
  logic                   ready;
  logic                   entry_barrier;
  logic                   exit_barrier;
  logic                   pulse_key;
  logic [SAMPLE_BITS-1:0] color_sample;
  logic                   white_waiting;
  logic                   red_waiting;
  logic                   blue_waiting;

  modport source (
    output valid, entry_barrier, exit_barrier, pulse_key, color_sample,
           white_waiting, red_waiting, blue_waiting,
    input  ready
  );
  modport sink (
    input  valid, entry_barrier, exit_barrier, pulse_key, color_sample,
           white_waiting, red_waiting, blue_waiting,
    output ready
  );
endinterface

interface cscc_result_if ();
  logic       valid;
  logic       ready;
  logic       conveyor_on;
  logic       compressor_on;
  logic       eject_white;
  logic       eject_red;
  logic       eject_blue;
  logic       lamp_white;
  logic       lamp_red;
  logic       lamp_blue;
  logic [1:0] phase_now;

  modport source (
    output valid, conveyor_on, compressor_on, eject_white, eject_red, eject_blue,
           lamp_white, lamp_red, lamp_blue, phase_now,
    input  ready
  );
  modport sink (
    input  valid, conveyor_on, compressor_on, eject_white, eject_red, eject_blue,
           lamp_white, lamp_red, lamp_blue, phase_now,
    output ready
  );
endinterface

interface cscc_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [cscc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [cscc_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/color_sort_conveyor_controller.sv =====
// Top level of the color sorting conveyor controller: phase sequencer and result register.
// A result beat is registered from its sensor beat and appears in the cycle after that beat is accepted.
// Throughput: one sensor beat per cycle; the result register takes the next beat in the
// cycle its current result is taken, and stalls input only when it is full and not taken.
// Reset (synchronous, rst high) returns to waiting with conveyor and compressor off,
// the color minimum at its start value and the configuration and sequencer registers at their defaults.
`include "assert_macros.svh"

module color_sort_conveyor_controller #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  cscc_item_if.sink     items,
  cscc_result_if.source results,
  cscc_cfg_if.sink      cfg
);

  localparam int STEP_BITS = cscc_pkg::STEP_BITS;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] min_start;
  logic [SAMPLE_BITS-1:0] white_limit;
  logic [SAMPLE_BITS-1:0] red_limit;
  logic [STEP_BITS-1:0]   steps_white;
  logic [STEP_BITS-1:0]   steps_red;
  logic [STEP_BITS-1:0]   steps_blue;

  // Sequencer state.
  cscc_pkg::phase_t       phase, phase_next;
  logic [SAMPLE_BITS-1:0] color_min, color_min_next;
  logic [STEP_BITS-1:0]   steps_left, steps_left_next;
  logic                   key_prev, key_prev_next;
  cscc_pkg::class_t       sort_class, sort_class_next;
  logic                   conveyor_reg, conveyor_reg_next;
  logic                   compressor_reg, compressor_reg_next;

  cscc_pkg::result_t      result, result_next;
  logic                   result_valid;

  logic                   item_accept;
  logic [SAMPLE_BITS-1:0] sample_min;
  logic [STEP_BITS-1:0]   steps_dec;
  logic                   comp_out;
  logic                   eject_w, eject_r, eject_b;

  // The config data is sized for the widest limit; fit it to the sample width.
  logic [cscc_pkg::CFG_DATA_BITS+SAMPLE_BITS-1:0] cfg_ext;
  logic [SAMPLE_BITS-1:0]                          cfg_sample;

  assign cfg_ext    = {{SAMPLE_BITS{1'b0}}, cfg.data};
  assign cfg_sample = cfg_ext[SAMPLE_BITS-1:0];
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_start   <= SAMPLE_BITS'(cscc_pkg::MIN_START_RESET);
      white_limit <= SAMPLE_BITS'(cscc_pkg::WHITE_LIMIT_RESET);
      red_limit   <= SAMPLE_BITS'(cscc_pkg::RED_LIMIT_RESET);
      steps_white <= cscc_pkg::STEPS_WHITE_RESET;
      steps_red   <= cscc_pkg::STEPS_RED_RESET;
      steps_blue  <= cscc_pkg::STEPS_BLUE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        cscc_pkg::REG_MIN_START:   min_start   <= cfg_sample;
        cscc_pkg::REG_WHITE_LIMIT: white_limit <= cfg_sample;
        cscc_pkg::REG_RED_LIMIT:   red_limit   <= cfg_sample;
        cscc_pkg::REG_STEPS_WHITE: steps_white <= cfg.data[STEP_BITS-1:0];
        cscc_pkg::REG_STEPS_RED:   steps_red   <= cfg.data[STEP_BITS-1:0];
        cscc_pkg::REG_STEPS_BLUE:  steps_blue  <= cfg.data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign items.ready = !result_valid || results.ready;
  assign item_accept = items.valid && items.ready;

  assign sample_min = (items.color_sample < color_min) ? items.color_sample : color_min;
  // A rising key edge counts down, saturating at zero.
  assign steps_dec = (items.pulse_key && !key_prev && (steps_left != '0)) ?
                     steps_left - STEP_BITS'(1) : steps_left;

  // Next state.
  always_comb begin
    phase_next          = phase;
    color_min_next      = color_min;
    steps_left_next     = steps_left;
    key_prev_next       = key_prev;
    sort_class_next     = sort_class;
    conveyor_reg_next   = conveyor_reg;
    compressor_reg_next = compressor_reg;
    case (phase)
      cscc_pkg::PH_WAIT: begin
        if (!items.entry_barrier) begin
          phase_next        = cscc_pkg::PH_SENSE;
          conveyor_reg_next = 1'b1;
          color_min_next    = min_start;
        end
      end
      cscc_pkg::PH_SENSE: begin
        color_min_next = sample_min;
        if (!items.exit_barrier) begin
          phase_next          = cscc_pkg::PH_MOVE;
          compressor_reg_next = 1'b1;
          if (sample_min < white_limit) begin
            steps_left_next = steps_white;
            sort_class_next = cscc_pkg::CLS_WHITE;
          end else if (sample_min < red_limit) begin
            steps_left_next = steps_red;
            sort_class_next = cscc_pkg::CLS_RED;
          end else begin
            steps_left_next = steps_blue;
            sort_class_next = cscc_pkg::CLS_BLUE;
          end
        end
      end
      cscc_pkg::PH_MOVE: begin
        steps_left_next = steps_dec;
        key_prev_next   = items.pulse_key;
        if (steps_dec <= STEP_BITS'(1)) begin
          phase_next        = cscc_pkg::PH_EJECT;
          conveyor_reg_next = 1'b0;
        end
      end
      cscc_pkg::PH_EJECT: begin
        sort_class_next     = cscc_pkg::CLS_NONE;
        compressor_reg_next = 1'b0;
        phase_next          = cscc_pkg::PH_WAIT;
      end
      default: ;
    endcase
  end

  // Outputs of the tick.
  always_comb begin
    comp_out = compressor_reg;
    eject_w  = 1'b0;
    eject_r  = 1'b0;
    eject_b  = 1'b0;
    case (phase)
      cscc_pkg::PH_SENSE: comp_out = compressor_reg_next;
      cscc_pkg::PH_EJECT: begin
        eject_w = (sort_class == cscc_pkg::CLS_WHITE);
        eject_r = (sort_class == cscc_pkg::CLS_RED);
        eject_b = (sort_class == cscc_pkg::CLS_BLUE);
      end
      default: ;
    endcase
    result_next.conveyor_on   = conveyor_reg_next;
    result_next.compressor_on = comp_out;
    result_next.eject_white   = eject_w;
    result_next.eject_red     = eject_r;
    result_next.eject_blue    = eject_b;
    result_next.lamp_white    = !items.white_waiting;
    result_next.lamp_red      = !items.red_waiting;
    result_next.lamp_blue     = !items.blue_waiting;
    result_next.phase_now     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cscc_pkg::PH_WAIT;
      color_min      <= SAMPLE_BITS'(cscc_pkg::MIN_START_RESET);
      steps_left     <= '0;
      key_prev       <= 1'b0;
      sort_class     <= cscc_pkg::CLS_NONE;
      conveyor_reg   <= 1'b0;
      compressor_reg <= 1'b0;
    end else if (item_accept) begin
      phase          <= phase_next;
      color_min      <= color_min_next;
      steps_left     <= steps_left_next;
      key_prev       <= key_prev_next;
      sort_class     <= sort_class_next;
      conveyor_reg   <= conveyor_reg_next;
      compressor_reg <= compressor_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_accept) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      result <= result_next;
    end
  end

  assign results.valid         = result_valid;
  assign results.conveyor_on   = result.conveyor_on;
  assign results.compressor_on = result.compressor_on;
  assign results.eject_white   = result.eject_white;
  assign results.eject_red     = result.eject_red;
  assign results.eject_blue    = result.eject_blue;
  assign results.lamp_white    = result.lamp_white;
  assign results.lamp_red      = result.lamp_red;
  assign results.lamp_blue     = result.lamp_blue;
  assign results.phase_now     = result.phase_now;

  // The conveyor runs exactly while a part is being sensed or moved.
  `ASSERT_ALWAYS(a_conveyor_phase, clk, rst,
    conveyor_reg == (phase == cscc_pkg::PH_SENSE || phase == cscc_pkg::PH_MOVE),
    "conveyor drive disagrees with phase")
  // The compressor holds from classification until the eject tick is done.
  `ASSERT_ALWAYS(a_compressor_phase, clk, rst,
    compressor_reg == (phase == cscc_pkg::PH_MOVE || phase == cscc_pkg::PH_EJECT),
    "compressor drive disagrees with phase")
  // At most one ejector fires for a result beat.
  `ASSERT_ALWAYS(a_eject_onehot, clk, rst,
    !result_valid || $onehot0({result.eject_white, result.eject_red, result.eject_blue}),
    "more than one ejector pulsed")
  // An accepted beat in the eject phase always returns the sequencer to waiting.
  `ASSERT_NEXT(a_eject_to_wait, clk, rst,
    item_accept && phase == cscc_pkg::PH_EJECT,
    phase == cscc_pkg::PH_WAIT && sort_class == cscc_pkg::CLS_NONE,
    "eject tick did not return to waiting")

endmodule
